// ===== rtl/core/atrs_pkg.sv =====
// shared widths, control structs and helper functions for the tridiagonal row setup
`timescale 1ns / 1ps
`default_nettype none

package atrs_pkg;

    localparam int WORD_W = 32;                  // data word, signed Q16.16
    localparam int CFG_W  = 31;                  // configuration registers, unsigned Q15.16
    localparam int FRAC_W = 16;                  // fraction bits of Q16.16
    localparam int MAG_W  = 35;                  // magnitude of a three-term diffusion sum
    localparam int OPB_W  = 32;                  // magnitude of the second multiplier operand
    localparam int HALF_W = OPB_W / 2;           // multiplier slice of the second operand
    localparam int ACC_W  = MAG_W + OPB_W;       // full product
    localparam int PROD_W = ACC_W - FRAC_W;      // product after dropping the fraction
    localparam int WIDE_W = PROD_W + 3;          // exact coefficient and denominator sums
    localparam int DIV_W  = 49;                  // denominator magnitude
    localparam int QUO_W  = WORD_W + 1;          // quotient of 2^32 by the denominator
    localparam int CNT_W  = $clog2(QUO_W);       // divider bit counter

    // multiplier pass control
    typedef struct packed {
        logic en;
        logic upper;
    } mul_ctl_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // magnitude of a signed word, 2^31 included
    function automatic logic [WORD_W-1:0] abs_word(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        r = v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
        return r;
    endfunction

    // clamp an exact sum to a signed word
    function automatic logic [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi_lim;
        logic signed [WIDE_W-1:0] lo_lim;
        logic [WORD_W-1:0]        r;
        hi_lim = signed'(WIDE_W'({1'b0, {(WORD_W-1){1'b1}}}));
        lo_lim = -hi_lim - signed'(WIDE_W'(1));
        if (v > hi_lim) begin
            r = {1'b0, {(WORD_W-1){1'b1}}};
        end else if (v < lo_lim) begin
            r = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/adi_tridiagonal_row_setup.sv =====
// top level: operand capture, sequencer, coefficient assembly and pivot chain
`timescale 1ns / 1ps
`default_nettype none

// Takes the cells of one grid row or column in order and returns, per cell, the upwind
// lower, diagonal and upper coefficients and the reciprocal forward-sweep pivot, all
// signed Q16.16, saturated to 32 bits. The pivot chains on the previous cell's upper
// coefficient and pivot; row_start (s_axis_tuser) drops that term for the first cell of a
// row. pivot_zero (m_axis_tuser) flags a zero denominator, where the pivot reads
// 0x7FFFFFFF. The block works on one item at a time and takes the next only once the
// previous result is registered: eight products go through one 35x16 multiplier in
// two passes each (with a few combine steps between dependent ones), then a restoring
// divider forms the reciprocal. s_axis_tready is high only
// while the block waits for an item; a finished result waits in the output register and
// does not block the next item until that item itself is done. Configuration registers
// are written through cfg_* at any time and are assumed quiet while an item is in work.
module adi_tridiagonal_row_setup (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration write: 0 inv_two_step_sq, 1 inv_step, 2 time_term
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [30:0]  cfg_data,
    // cell input
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_code[2:0], diff_prev, diff_here, diff_next, vel_prev, vel_here, vel_next, pad
    input  wire logic [199:0] s_axis_tdata,
    // row_start
    input  wire logic [0:0]   s_axis_tuser,
    // coefficient output
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // coef_lower, coef_diag, coef_upper, pivot_recip
    output logic [127:0]      m_axis_tdata,
    // pivot_zero
    output logic [0:0]        m_axis_tuser
);
    import atrs_pkg::*;

    localparam logic [1:0] REG_INV_SQ = 2'd0;
    localparam logic [1:0] REG_INV_H  = 2'd1;
    localparam logic [1:0] REG_TIME   = 2'd2;

    localparam logic [2:0] POS_OPEN  = 3'd0;
    localparam logic [2:0] POS_LEFT  = 3'd1;
    localparam logic [2:0] POS_RIGHT = 3'd2;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_COEF   = 3'd3;
    localparam logic [2:0] S_PONE   = 3'd4;
    localparam logic [2:0] S_DEN    = 3'd5;
    localparam logic [2:0] S_DSTART = 3'd6;
    localparam logic [2:0] S_DIV    = 3'd7;

    // products, in issue order
    localparam logic [2:0] OP_A = 3'd0;   // (sm + s) * inv_two_step_sq
    localparam logic [2:0] OP_B = 3'd1;   // (s + sp) * inv_two_step_sq
    localparam logic [2:0] OP_C = 3'd2;   // (sm + 2s + sp) * inv_two_step_sq
    localparam logic [2:0] OP_D = 3'd3;   // |vel_prev| * inv_step
    localparam logic [2:0] OP_E = 3'd4;   // |vel_here| * inv_step
    localparam logic [2:0] OP_F = 3'd5;   // |vel_next| * inv_step
    localparam logic [2:0] OP_G = 3'd6;   // last_upper * lower
    localparam logic [2:0] OP_H = 3'd7;   // chained product * last_pivot

    localparam logic [WORD_W-1:0] PIV_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] PIV_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // control
    logic [2:0]  state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    logic        phase_reg, phase_next;
    logic        cap_pending_reg;
    logic [2:0]  cap_idx_reg;
    logic        m_valid_reg, m_valid_next;
    logic        s_acc, finish;

    // configuration and chain state
    logic [CFG_W-1:0]  k2_reg, k1_reg, tt_reg;
    logic [WORD_W-1:0] last_upper_reg, last_pivot_reg;

    // cell operands
    logic [2:0]        pos_reg;
    logic              start_reg;
    logic [MAG_W-1:0]  mag_sl_reg, mag_su_reg, mag_sd_reg;
    logic              neg_sl_reg, neg_su_reg, neg_sd_reg;
    logic [WORD_W-1:0] mag_um_reg, mag_u_reg, mag_up_reg;
    logic              um_pos_reg, u_pos_reg, up_pos_reg;
    logic [PROD_W-1:0] prod_reg [8];

    // intermediate results
    logic [WORD_W-1:0] lo_reg, dg_reg, hi_reg, p1_reg;
    logic              den_neg_reg, den_zero_reg;
    logic [DIV_W-1:0]  den_mag_reg;
    logic [127:0]      m_data_reg;
    logic              m_zero_reg;

    // datapath wires
    logic signed [WIDE_W-1:0] s_sl, s_su, s_sd;
    logic signed [WIDE_W-1:0] pa, pb, pc, pd, pe, pf, pg, ph;
    logic signed [WIDE_W-1:0] a_sg, b_sg, c_sg, g_sg, h_sg;
    logic signed [WIDE_W-1:0] lo_w, dg_w, hi_w, den_w;
    logic [WIDE_W-1:0]        den_abs;
    logic [WORD_W-1:0]        vp, vh, vn, sm, sh, sn;
    logic [WORD_W-1:0]        piv;
    mul_ctl_t                 mul_ctl;
    logic [MAG_W-1:0]         mul_a;
    logic [OPB_W-1:0]         mul_b;
    logic [ACC_W-1:0]         mul_acc;
    div_stat_t                div_stat;
    logic [QUO_W-1:0]         quo;
    logic                     div_start;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign finish        = (state_reg == S_DIV) && div_stat.done
                           && (!m_valid_reg || m_axis_tready);
    assign div_start     = (state_reg == S_DSTART);

    assign sm = s_axis_tdata[34:3];
    assign sh = s_axis_tdata[66:35];
    assign sn = s_axis_tdata[98:67];
    assign vp = s_axis_tdata[130:99];
    assign vh = s_axis_tdata[162:131];
    assign vn = s_axis_tdata[194:163];

    // diffusion sums, exact
    always_comb begin
        s_sl = signed'(WIDE_W'(signed'(sm))) + signed'(WIDE_W'(signed'(sh)));
        s_su = signed'(WIDE_W'(signed'(sh))) + signed'(WIDE_W'(signed'(sn)));
        s_sd = s_sl + s_su;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        phase_next = phase_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    state_next = S_MUL;
                    op_next    = OP_A;
                    phase_next = 1'b0;
                end
            end
            S_MUL: begin
                phase_next = !phase_reg;
                if (phase_reg) begin
                    if (op_reg == OP_F || op_reg == OP_G || op_reg == OP_H) begin
                        state_next = S_WAIT;
                    end else begin
                        op_next = op_reg + 3'd1;
                    end
                end
            end
            S_WAIT: begin
                // last product lands in its register during this cycle
                case (op_reg)
                    OP_F:    state_next = S_COEF;
                    OP_G:    state_next = S_PONE;
                    default: state_next = S_DEN;
                endcase
            end
            S_COEF: begin
                state_next = S_MUL;
                op_next    = OP_G;
                phase_next = 1'b0;
            end
            S_PONE: begin
                state_next = S_MUL;
                op_next    = OP_H;
                phase_next = 1'b0;
            end
            S_DEN:    state_next = S_DSTART;
            S_DSTART: state_next = S_DIV;
            S_DIV: begin
                if (finish) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // multiplier operands
    always_comb begin
        mul_ctl.en    = (state_reg == S_MUL);
        mul_ctl.upper = phase_reg;
        case (op_reg)
            OP_A: begin
                mul_a = mag_sl_reg;
                mul_b = OPB_W'(k2_reg);
            end
            OP_B: begin
                mul_a = mag_su_reg;
                mul_b = OPB_W'(k2_reg);
            end
            OP_C: begin
                mul_a = mag_sd_reg;
                mul_b = OPB_W'(k2_reg);
            end
            OP_D: begin
                mul_a = MAG_W'(mag_um_reg);
                mul_b = OPB_W'(k1_reg);
            end
            OP_E: begin
                mul_a = MAG_W'(mag_u_reg);
                mul_b = OPB_W'(k1_reg);
            end
            OP_F: begin
                mul_a = MAG_W'(mag_up_reg);
                mul_b = OPB_W'(k1_reg);
            end
            OP_G: begin
                mul_a = MAG_W'(abs_word(last_upper_reg));
                mul_b = abs_word(lo_reg);
            end
            default: begin
                mul_a = MAG_W'(abs_word(p1_reg));
                mul_b = abs_word(last_pivot_reg);
            end
        endcase
    end

    atrs_mulacc u_mul (
        .aclk  (aclk),
        .ctl   (mul_ctl),
        .a_mag (mul_a),
        .b_mag (mul_b),
        .acc   (mul_acc)
    );

    atrs_recip u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .den_mag (den_mag_reg),
        .stat    (div_stat),
        .quo     (quo)
    );

    // coefficient assembly, chained product and denominator
    always_comb begin
        pa   = signed'(WIDE_W'(prod_reg[OP_A]));
        pb   = signed'(WIDE_W'(prod_reg[OP_B]));
        pc   = signed'(WIDE_W'(prod_reg[OP_C]));
        pd   = signed'(WIDE_W'(prod_reg[OP_D]));
        pe   = signed'(WIDE_W'(prod_reg[OP_E]));
        pf   = signed'(WIDE_W'(prod_reg[OP_F]));
        pg   = signed'(WIDE_W'(prod_reg[OP_G]));
        ph   = signed'(WIDE_W'(prod_reg[OP_H]));
        a_sg = neg_sl_reg ? -pa : pa;
        b_sg = neg_su_reg ? -pb : pb;
        c_sg = neg_sd_reg ? -pc : pc;
        lo_w = '0;
        dg_w = '0;
        hi_w = '0;
        case (pos_reg)
            POS_OPEN: begin
                lo_w = -a_sg - (um_pos_reg ? pd : '0);
                dg_w = c_sg + pe;
                hi_w = -b_sg - (up_pos_reg ? '0 : pf);
            end
            POS_LEFT: begin
                dg_w = b_sg + (u_pos_reg ? pe : '0);
                hi_w = -b_sg - (up_pos_reg ? '0 : pf);
            end
            POS_RIGHT: begin
                lo_w = -a_sg - (um_pos_reg ? pd : '0);
                dg_w = a_sg + (u_pos_reg ? '0 : pe);
            end
            default: begin
                // land and unused codes keep all three at zero
                lo_w = '0;
            end
        endcase
        g_sg    = (last_upper_reg[WORD_W-1] ^ lo_reg[WORD_W-1]) ? -pg : pg;
        h_sg    = (p1_reg[WORD_W-1] ^ last_pivot_reg[WORD_W-1]) ? -ph : ph;
        den_w   = signed'(WIDE_W'(signed'(dg_reg))) + signed'(WIDE_W'(tt_reg))
                  - (start_reg ? '0 : h_sg);
        den_abs = den_w[WIDE_W-1] ? WIDE_W'(-den_w) : WIDE_W'(den_w);
    end

    // signed, saturated reciprocal
    always_comb begin
        if (den_zero_reg) begin
            piv = PIV_MAX;
        end else if (!den_neg_reg) begin
            piv = (quo[QUO_W-1] || quo[WORD_W-1]) ? PIV_MAX : quo[WORD_W-1:0];
        end else if (quo[QUO_W-1] || (quo[WORD_W-1] && (quo[WORD_W-2:0] != '0))) begin
            piv = PIV_MIN;
        end else begin
            piv = ~quo[WORD_W-1:0] + WORD_W'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_A;
            phase_reg       <= 1'b0;
            cap_pending_reg <= 1'b0;
            cap_idx_reg     <= OP_A;
            m_valid_reg     <= 1'b0;
            k2_reg          <= CFG_W'(65536);
            k1_reg          <= CFG_W'(65536);
            tt_reg          <= '0;
            last_upper_reg  <= '0;
            last_pivot_reg  <= '0;
        end else begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            phase_reg       <= phase_next;
            // a product is complete in the cycle after its upper pass
            cap_pending_reg <= (state_reg == S_MUL) && phase_reg;
            cap_idx_reg     <= op_reg;
            m_valid_reg     <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_INV_SQ: k2_reg <= cfg_data;
                    REG_INV_H:  k1_reg <= cfg_data;
                    REG_TIME:   tt_reg <= cfg_data;
                    default:    ;
                endcase
            end
            if (finish) begin
                last_upper_reg <= hi_reg;
                last_pivot_reg <= piv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            pos_reg    <= s_axis_tdata[2:0];
            start_reg  <= s_axis_tuser[0];
            neg_sl_reg <= s_sl[WIDE_W-1];
            neg_su_reg <= s_su[WIDE_W-1];
            neg_sd_reg <= s_sd[WIDE_W-1];
            mag_sl_reg <= s_sl[WIDE_W-1] ? MAG_W'(-s_sl) : MAG_W'(s_sl);
            mag_su_reg <= s_su[WIDE_W-1] ? MAG_W'(-s_su) : MAG_W'(s_su);
            mag_sd_reg <= s_sd[WIDE_W-1] ? MAG_W'(-s_sd) : MAG_W'(s_sd);
            mag_um_reg <= abs_word(vp);
            mag_u_reg  <= abs_word(vh);
            mag_up_reg <= abs_word(vn);
            // zero velocity counts as not positive
            um_pos_reg <= !vp[WORD_W-1] && (vp != '0);
            u_pos_reg  <= !vh[WORD_W-1] && (vh != '0);
            up_pos_reg <= !vn[WORD_W-1] && (vn != '0);
        end
        if (cap_pending_reg) begin
            prod_reg[cap_idx_reg] <= mul_acc[ACC_W-1:FRAC_W];
        end
        if (state_reg == S_COEF) begin
            lo_reg <= sat_word(lo_w);
            dg_reg <= sat_word(dg_w);
            hi_reg <= sat_word(hi_w);
        end
        if (state_reg == S_PONE) begin
            p1_reg <= sat_word(g_sg);
        end
        if (state_reg == S_DEN) begin
            den_neg_reg  <= den_w[WIDE_W-1];
            den_zero_reg <= (den_w == '0);
            den_mag_reg  <= den_abs[DIV_W-1:0];
        end
        if (finish) begin
            m_data_reg <= {piv, hi_reg, dg_reg, lo_reg};
            m_zero_reg <= den_zero_reg;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_zero_reg;

endmodule

`default_nettype wire

// ===== rtl/core/atrs_mulacc.sv =====
// shared unsigned multiplier: one 16-bit slice of the second operand per pass, accumulated
`timescale 1ns / 1ps
`default_nettype none

module atrs_mulacc (
    input  wire logic                       aclk,
    input  wire atrs_pkg::mul_ctl_t         ctl,
    input  wire logic [atrs_pkg::MAG_W-1:0] a_mag,
    input  wire logic [atrs_pkg::OPB_W-1:0] b_mag,
    output logic [atrs_pkg::ACC_W-1:0]      acc
);
    import atrs_pkg::*;

    logic [HALF_W-1:0]       b_half;
    logic [MAG_W+HALF_W-1:0] part;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_next;

    always_comb begin
        b_half   = ctl.upper ? b_mag[OPB_W-1:HALF_W] : b_mag[HALF_W-1:0];
        part     = (MAG_W+HALF_W)'(a_mag) * (MAG_W+HALF_W)'(b_half);
        // lower slice starts the product, upper slice adds in one slice up
        acc_next = ctl.upper ? (acc_reg + {part, {HALF_W{1'b0}}}) : ACC_W'(part);
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/atrs_recip.sv =====
// restoring divider for 2^32 / den, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module atrs_recip (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [atrs_pkg::DIV_W-1:0] den_mag,
    output atrs_pkg::div_stat_t             stat,
    output logic [atrs_pkg::QUO_W-1:0]      quo
);
    import atrs_pkg::*;

    logic [DIV_W-1:0] div_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0] quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [DIV_W:0]   shifted;
    logic             qbit;

    always_comb begin
        // dividend has a single one, at the top quotient bit
        shifted   = {rem_reg, cnt_reg == CNT_W'(QUO_W - 1)};
        qbit      = shifted >= {1'b0, div_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            rem_next  = '0;
            cnt_next  = CNT_W'(QUO_W - 1);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            rem_next = qbit ? DIV_W'(shifted - {1'b0, div_reg}) : shifted[DIV_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], qbit};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= den_mag;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/atrs_checker.sv =====
// port-level checks for the tridiagonal row setup, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module atrs_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         cfg_valid,
    input wire logic         cfg_ready,
    input wire logic [1:0]   cfg_index,
    input wire logic [30:0]  cfg_data,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic [199:0] s_axis_tdata,
    input wire logic [0:0]   s_axis_tuser,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata,
    input wire logic [0:0]   m_axis_tuser
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an item was taken");

    // a zero denominator reads as the largest positive pivot
    a_zero_pivot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[127:96] == 32'h7FFF_FFFF)
        else $error("pivot_zero without saturated pivot");

    // a new result only appears while an item is in work
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind adi_tridiagonal_row_setup atrs_checker u_atrs_checker (.*);

`default_nettype wire

// ===== test/adi_tridiagonal_row_setup_tb.sv =====
// testbench for the tridiagonal row setup: directed and random cells checked against a predictor
`timescale 1ns / 1ps

module adi_tridiagonal_row_setup_tb;

    import atrs_pkg::WORD_W;
    import atrs_pkg::CFG_W;

    localparam logic [1:0] REG_INV_TWO_STEP_SQ = 2'd0;
    localparam logic [1:0] REG_INV_STEP        = 2'd1;
    localparam logic [1:0] REG_TIME_TERM       = 2'd2;
    localparam logic [1:0] REG_UNUSED          = 2'd3;

    localparam logic [2:0] POS_OPEN         = 3'd0;
    localparam logic [2:0] POS_CLOSED_LEFT  = 3'd1;
    localparam logic [2:0] POS_CLOSED_RIGHT = 3'd2;
    localparam logic [2:0] POS_LAND         = 3'd3;
    localparam logic [2:0] POS_OTHER        = 3'd4;

    localparam longint WORD_MAX = 64'sh7FFF_FFFF;
    localparam longint WORD_MIN = -WORD_MAX - 1;
    localparam logic [CFG_W-1:0] REG_MAX = {CFG_W{1'b1}};
    localparam logic [CFG_W-1:0] Q_ONE   = 31'd65536;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [2:0]               pos_code;
        logic signed [WORD_W-1:0] diff_prev;
        logic signed [WORD_W-1:0] diff_here;
        logic signed [WORD_W-1:0] diff_next;
        logic signed [WORD_W-1:0] vel_prev;
        logic signed [WORD_W-1:0] vel_here;
        logic signed [WORD_W-1:0] vel_next;
        logic                     row_start;
    } cell_t;

    typedef struct {
        logic [WORD_W-1:0] coef_lower;
        logic [WORD_W-1:0] coef_diag;
        logic [WORD_W-1:0] coef_upper;
        logic [WORD_W-1:0] pivot_recip;
        logic              pivot_zero;
    } coef_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [30:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    // predictor state and register copies
    longint          chain_upper;
    longint          chain_pivot;
    longint unsigned two_step_sq_q;
    longint unsigned step_q;
    longint unsigned time_term_q;

    coef_t expected_coefs[$];
    int    fail_count;
    int    cycle_count;
    bit    src_idle_on;
    bit    sink_idle_on;
    int    sink_hold;

    adi_tridiagonal_row_setup dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("adi_tridiagonal_row_setup test failed");
        $finish;
    end

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    // Q16.16 times a register, magnitude truncated before the sign goes back on
    function automatic longint scale_by_reg(input longint a, input longint unsigned k);
        longint unsigned m;
        longint unsigned r;
        m = (a < 0) ? -a : a;
        r = m * (k >> 16) + ((m * (k & 64'hFFFF)) >> 16);
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint mul_q(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        r  = (ma * mb) >> 16;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic coef_t predict_row_coefs(input cell_t c);
        coef_t           e;
        longint          sm, s, sp, um, u, up;
        longint          lo, dg, hi, den, piv, p1;
        longint unsigned mag, quo;
        sm = c.diff_prev;
        s  = c.diff_here;
        sp = c.diff_next;
        um = c.vel_prev;
        u  = c.vel_here;
        up = c.vel_next;
        lo = 0;
        dg = 0;
        hi = 0;
        if (c.pos_code == POS_OPEN || c.pos_code == POS_CLOSED_RIGHT) begin
            lo = -scale_by_reg(sm + s, two_step_sq_q);
            if (um > 0) lo -= scale_by_reg(um, step_q);
        end
        case (c.pos_code)
            POS_OPEN: begin
                dg = scale_by_reg(sm + 2 * s + sp, two_step_sq_q)
                   + scale_by_reg((u > 0) ? u : -u, step_q);
            end
            POS_CLOSED_LEFT: begin
                dg = scale_by_reg(s + sp, two_step_sq_q);
                if (u > 0) dg += scale_by_reg(u, step_q);
            end
            POS_CLOSED_RIGHT: begin
                dg = scale_by_reg(sm + s, two_step_sq_q);
                if (u <= 0) dg += scale_by_reg(-u, step_q);
            end
            default: ;
        endcase
        if (c.pos_code == POS_OPEN || c.pos_code == POS_CLOSED_LEFT) begin
            hi = -scale_by_reg(s + sp, two_step_sq_q);
            if (up <= 0) hi += scale_by_reg(up, step_q);
        end
        lo = clamp_word(lo);
        dg = clamp_word(dg);
        hi = clamp_word(hi);

        den = dg + longint'(time_term_q);
        if (!c.row_start) begin
            p1 = clamp_word(mul_q(chain_upper, lo));
            den -= mul_q(p1, chain_pivot);
        end
        if (den == 0) begin
            piv = WORD_MAX;
            e.pivot_zero = 1'b1;
        end else begin
            mag = (den < 0) ? -den : den;
            quo = (64'd1 << 32) / mag;
            if (quo > (64'd1 << 40)) quo = 64'd1 << 40;
            piv = clamp_word((den < 0) ? -longint'(quo) : longint'(quo));
            e.pivot_zero = 1'b0;
        end
        chain_upper = hi;
        chain_pivot = piv;
        e.coef_lower  = WORD_W'(lo);
        e.coef_diag   = WORD_W'(dg);
        e.coef_upper  = WORD_W'(hi);
        e.pivot_recip = WORD_W'(piv);
        return e;
    endfunction

    function automatic cell_t make_cell(input logic [2:0] pos, input longint dp,
                                        input longint dh, input longint dn,
                                        input longint vp, input longint vh,
                                        input longint vn, input logic start);
        cell_t c;
        c.pos_code  = pos;
        c.diff_prev = WORD_W'(dp);
        c.diff_here = WORD_W'(dh);
        c.diff_next = WORD_W'(dn);
        c.vel_prev  = WORD_W'(vp);
        c.vel_here  = WORD_W'(vh);
        c.vel_next  = WORD_W'(vn);
        c.row_start = start;
        return c;
    endfunction

    // full-range word with the extremes drawn often
    function automatic longint wild_word();
        case ($urandom_range(0, 7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return 0;
            3: return -1;
            default: return longint'(int'($urandom));
        endcase
    endfunction

    function automatic cell_t random_cell(input bit tame, input logic start);
        cell_t      c;
        logic [2:0] pos;
        int         pick;
        if (tame) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) pos = POS_OPEN;
            else if (pick == 6) pos = POS_CLOSED_LEFT;
            else if (pick == 7) pos = POS_CLOSED_RIGHT;
            else if (pick == 8) pos = POS_LAND;
            else pos = 3'($urandom_range(POS_OTHER, 7));
            c = make_cell(pos,
                          longint'($urandom_range(0, 20 * 65536)),
                          longint'($urandom_range(0, 20 * 65536)),
                          longint'($urandom_range(0, 20 * 65536)),
                          longint'($urandom_range(0, 10 * 65536)) - 5 * 65536,
                          longint'($urandom_range(0, 10 * 65536)) - 5 * 65536,
                          longint'($urandom_range(0, 10 * 65536)) - 5 * 65536, start);
        end else begin
            c = make_cell(3'($urandom_range(0, 7)), wild_word(), wild_word(), wild_word(),
                          wild_word(), wild_word(), wild_word(), start);
        end
        return c;
    endfunction

    task automatic send_cell(input cell_t c);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, c.vel_next, c.vel_here, c.vel_prev,
                          c.diff_next, c.diff_here, c.diff_prev, c.pos_code};
        s_axis_tuser  <= c.row_start;
        expected_coefs.push_back(predict_row_coefs(c));
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic wait_results_done();
        // valid is only still up right after an accepted item, whose result is pending
        if (expected_coefs.size() != 0) begin
            s_axis_tvalid <= 1'b0;
        end
        while (expected_coefs.size() != 0) @(posedge aclk);
    endtask

    // only called while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_INV_TWO_STEP_SQ: two_step_sq_q = val;
            REG_INV_STEP:        step_q = val;
            REG_TIME_TERM:       time_term_q = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] k2, input logic [CFG_W-1:0] k1,
                            input logic [CFG_W-1:0] tt);
        wait_results_done();
        write_reg(REG_INV_TWO_STEP_SQ, k2);
        write_reg(REG_INV_STEP, k1);
        write_reg(REG_TIME_TERM, tt);
    endtask

    // rows of random length, row_start on the first cell with a little noise
    task automatic send_rows(input int n_items, input int tame_pct);
        int   sent;
        int   len;
        logic start;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 24);
            for (int i = 0; i < len && sent < n_items; i++) begin
                start = (i == 0);
                if ($urandom_range(0, 29) == 0) start = ~start;
                send_cell(random_cell($urandom_range(0, 99) < tame_pct, start));
                sent++;
            end
        end
    endtask

    task automatic test_special_cells();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        // land and unused codes give zero coefficients, so a zero time term leaves den zero
        send_cell(make_cell(POS_LAND, 0, 0, 0, 0, 0, 0, 1'b1));
        send_cell(make_cell(POS_LAND, 65536, 65536, 65536, 65536, 65536, 65536, 1'b0));
        send_cell(make_cell(POS_OTHER, 3 << 16, 1 << 16, 2 << 16, 1 << 16, -1, 5, 1'b1));
        for (int p = 5; p <= 7; p++) begin
            send_cell(make_cell(3'(p), WORD_MAX, WORD_MIN, -1, WORD_MIN, WORD_MAX, 1, 1'b0));
        end
        send_cell(make_cell(POS_OPEN, 1 << 16, 1 << 16, 1 << 16, 0, 0, 0, 1'b1));
        send_cell(make_cell(POS_OPEN, 1 << 16, 2 << 16, 1 << 16, 1 << 16, 2 << 16, 3 << 16,
                            1'b0));
        send_cell(make_cell(POS_OPEN, 1 << 16, 2 << 16, 1 << 16, -1 << 16, -2 << 16, -3 << 16,
                            1'b0));
        send_cell(make_cell(POS_CLOSED_LEFT, 0, 2 << 16, 1 << 16, 0, 1 << 16, -1 << 16, 1'b0));
        send_cell(make_cell(POS_CLOSED_LEFT, 0, 2 << 16, 1 << 16, 0, -1 << 16, 1 << 16, 1'b0));
        send_cell(make_cell(POS_CLOSED_RIGHT, 1 << 16, 2 << 16, 0, 1 << 16, 0, 0, 1'b0));
        send_cell(make_cell(POS_CLOSED_RIGHT, 1 << 16, 2 << 16, 0, -1 << 16, 1 << 16, 0,
                            1'b0));
        // denominator of one lsb: the reciprocal saturates both ways without the zero flag
        send_cell(make_cell(POS_OPEN, 1, 0, 0, 0, 0, 0, 1'b1));
        send_cell(make_cell(POS_CLOSED_RIGHT, -1, 0, 0, 0, 0, 0, 1'b1));
        wait_results_done();
    endtask

    task automatic test_field_extremes();
        set_regs(REG_MAX, REG_MAX, REG_MAX);
        for (int p = 0; p < 4; p++) begin
            send_cell(make_cell(3'(p), WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN,
                                WORD_MIN, 1'b0));
            send_cell(make_cell(3'(p), WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX,
                                WORD_MAX, 1'b0));
        end
        wait_results_done();
    endtask

    task automatic test_register_sweep();
        set_regs(Q_ONE, Q_ONE, '0);
        // a write beyond the register list must change nothing
        write_reg(REG_UNUSED, REG_MAX);
        send_rows(6, 70);
        set_regs('0, '0, '0);
        send_rows(6, 70);
        set_regs(REG_MAX, '0, '0);
        send_rows(6, 50);
        set_regs('0, REG_MAX, REG_MAX);
        send_rows(6, 50);
        wait_results_done();
    endtask

    task automatic test_output_stall();
        set_regs(CFG_W'(2 * Q_ONE), Q_ONE, CFG_W'(8 * Q_ONE));
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        sink_hold    = 500;
        send_rows(10, 80);
        wait_results_done();
    endtask

    task automatic test_sender_pause();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (int k = 0; k < 3; k++) begin
            send_rows(4, 80);
            wait_results_done();
        end
    endtask

    task automatic test_random_rows();
        for (int phase = 0; phase < 10; phase++) begin
            case (phase % 6)
                0: set_regs(Q_ONE, Q_ONE, '0);
                1: set_regs(CFG_W'($urandom_range(0, 4 << 16)),
                            CFG_W'($urandom_range(0, 4 << 16)),
                            CFG_W'($urandom_range(0, 64 << 16)));
                2: set_regs(REG_MAX, REG_MAX, REG_MAX);
                3: set_regs('0, '0, '0);
                4: set_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
                default: set_regs(CFG_W'($urandom_range(0, 4 << 16)),
                                  CFG_W'($urandom_range(0, 4 << 16)), '0);
            endcase
            src_idle_on  = phase[0];
            sink_idle_on = phase[1];
            send_rows(140, 70);
        end
        wait_results_done();
    endtask

    // receiver: random stall after each item when sink_idle_on is set, plus a long hold when asked
    initial begin : result_sink
        int   stall_left;
        logic ready_nxt;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            ready_nxt = 1'b1;
            if (m_axis_tvalid && m_axis_tready) begin
                stall_left = sink_idle_on ? $urandom_range(0, 15) : 0;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                ready_nxt = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_nxt = 1'b0;
            end
            m_axis_tready <= ready_nxt;
        end
    end

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        fail_count++;
    endtask

    always @(posedge aclk) begin : result_check
        coef_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_coefs.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h %b", $time,
                         m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                e = expected_coefs.pop_front();
                if (m_axis_tdata[31:0] !== e.coef_lower)
                    report_mismatch("coef_lower", e.coef_lower, m_axis_tdata[31:0]);
                if (m_axis_tdata[63:32] !== e.coef_diag)
                    report_mismatch("coef_diag", e.coef_diag, m_axis_tdata[63:32]);
                if (m_axis_tdata[95:64] !== e.coef_upper)
                    report_mismatch("coef_upper", e.coef_upper, m_axis_tdata[95:64]);
                if (m_axis_tdata[127:96] !== e.pivot_recip)
                    report_mismatch("pivot_recip", e.pivot_recip, m_axis_tdata[127:96]);
                if (m_axis_tuser[0] !== e.pivot_zero)
                    report_mismatch("pivot_zero", WORD_W'(e.pivot_zero), WORD_W'(m_axis_tuser));
            end
        end
    end

    initial begin
        fail_count    = 0;
        cycle_count   = 0;
        sink_hold     = 0;
        src_idle_on   = 1'b0;
        sink_idle_on  = 1'b0;
        chain_upper   = 0;
        chain_pivot   = 0;
        two_step_sq_q = Q_ONE;
        step_q        = Q_ONE;
        time_term_q   = 0;
        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_INV_TWO_STEP_SQ;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_special_cells();
        test_field_extremes();
        test_register_sweep();
        test_output_stall();
        test_sender_pause();
        test_random_rows();

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("adi_tridiagonal_row_setup test passed");
        end else begin
            $display("adi_tridiagonal_row_setup test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/atrs_pkg.sv
rtl/core/atrs_mulacc.sv
rtl/core/atrs_recip.sv
rtl/core/adi_tridiagonal_row_setup.sv
rtl/core/atrs_checker.sv
test/adi_tridiagonal_row_setup_tb.sv
